FILE: rtl/mssd_pkg.sv
package mssd_pkg;

	localparam int SPEED_W          = 16;
	localparam int MAG_W            = SPEED_W + 1;
	localparam int SUM_W            = 21;
	localparam int PRESENT_W        = 3;
	localparam int MAX_CHANNELS     = 4;
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int WINDOW_DEF       = 50;

	localparam logic MODE_SAMPLE   = 1'b0;
	localparam logic MODE_OVERRIDE = 1'b1;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [SUM_W-1:0]          sum_t;
	typedef logic [MAG_W-1:0]          mag_t;

	typedef struct packed {
		logic                 mode;
		logic [PRESENT_W-1:0] channels_present;
		speed_t               speed_ch0;
		speed_t               speed_ch1;
		speed_t               speed_ch2;
		speed_t               speed_ch3;
		logic                 external_static;
	} speed_item_t;

	typedef struct packed {
		logic static_now;
		logic previous_static;
		sum_t max_window_sum;
	} status_item_t;

	// per-channel update request from the sample stage
	typedef struct packed {
		logic   wr;
		speed_t speed;
	} chan_req_t;

	// absolute value; the most negative speed gives 32768, which fits MAG_W bits
	function automatic mag_t mag16(speed_t s);
		mag_t ext;
		ext = {s[SPEED_W-1], s};
		return s[SPEED_W-1] ? mag_t'(-ext) : ext;
	endfunction

endpackage

FILE: rtl/mssd_if.sv
interface mssd_speed_if;
	logic                  valid;
	logic                  ready;
	mssd_pkg::speed_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mssd_status_if;
	logic                   valid;
	logic                   ready;
	mssd_pkg::status_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mssd_cfg_if;
	logic           valid;
	logic           ready;
	mssd_pkg::sum_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mssd_chan.sv
module mssd_chan #(
	parameter int WINDOW = mssd_pkg::WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mssd_pkg::chan_req_t req,
	output mssd_pkg::sum_t      sum_upd
);
	import mssd_pkg::*;

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	speed_t         mem [WINDOW];
	speed_t         oldest_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  pos_nxt;
	logic [PW-1:0]  raddr;
	logic [CW-1:0]  cnt_q;
	sum_t           sum_q;
	sum_t           sum_nxt;
	logic           full;
	mag_t           old_mag;

	assign full    = (cnt_q == CW'(WINDOW));
	assign old_mag = full ? mag16(oldest_q) : '0;
	assign sum_nxt = sum_q - SUM_W'(old_mag) + SUM_W'(mag16(req.speed));
	assign pos_nxt = (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + PW'(1);
	assign sum_upd = req.wr ? sum_nxt : sum_q;

	// look ahead to the slot the next sample will overwrite
	assign raddr = req.wr ? pos_nxt : pos_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[pos_q] <= req.speed;
		end
		if (req.wr && (raddr == pos_q)) begin
			oldest_q <= req.speed;
		end else begin
			oldest_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (req.wr) begin
			pos_q <= pos_nxt;
			sum_q <= sum_nxt;
			if (!full) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

FILE: rtl/mssd_judge.sv
module mssd_judge #(
	parameter int NUM_CHANNELS = mssd_pkg::NUM_CHANNELS_DEF
) (
	input  mssd_pkg::sum_t sums [NUM_CHANNELS],
	input  mssd_pkg::sum_t threshold,
	output mssd_pkg::sum_t best,
	output logic           at_rest
);
	import mssd_pkg::*;

	always_comb begin
		best = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (sums[c] > best) begin
				best = sums[c];
			end
		end
	end

	assign at_rest = (best <= threshold);

endmodule

FILE: rtl/multichannel_standstill_detector_unit.sv
// Channel  Role    Payload                                         Handshake
// speed    sink    mode, channels_present, speed_ch0..3, ext flag   valid/ready
// status   source  static_now, previous_static, max_window_sum      valid/ready
// cfg      sink    stop_threshold (21 bits)                         valid/ready, ready tied high
//
// One request enters per cycle unless the result stalls; it passes the input and result registers.
// The single stage between the input register and the result register updates the
// running sums and takes the maximum; the window memories are read one sample ahead.
// Reset clears sums, counts, write positions and both flags; window contents stay undefined.
// A stalled result holds the input stage, and the input accepts as soon as that stage moves.
module multichannel_standstill_detector_unit #(
	parameter int NUM_CHANNELS = mssd_pkg::NUM_CHANNELS_DEF,
	parameter int WINDOW       = mssd_pkg::WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mssd_speed_if.sink   speed,
	mssd_status_if.source status,
	mssd_cfg_if.sink     cfg
);
	import mssd_pkg::*;

	// input register
	logic         valid_s1;
	speed_item_t  item_s1;

	// result register, threshold and flag
	logic         res_valid_q;
	status_item_t res_q;
	sum_t         thr_q;
	logic         flag_q;

	logic                 advance;
	logic [PRESENT_W-1:0] present_sat;
	speed_t               spd [MAX_CHANNELS];
	sum_t                 sums [NUM_CHANNELS];
	sum_t                 best;
	logic                 at_rest;
	logic                 new_flag;

	// advance the stage whenever the result register is free or being emptied
	assign advance     = valid_s1 && (!res_valid_q || status.ready);
	assign speed.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	assign status.valid = res_valid_q;
	assign status.data  = res_q;

	// clamp the channel count to the channels actually built
	assign present_sat = (item_s1.channels_present > PRESENT_W'(NUM_CHANNELS))
		? PRESENT_W'(NUM_CHANNELS) : item_s1.channels_present;

	assign spd[0] = item_s1.speed_ch0;
	assign spd[1] = item_s1.speed_ch1;
	assign spd[2] = item_s1.speed_ch2;
	assign spd[3] = item_s1.speed_ch3;

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		chan_req_t req;

		// only leading present channels take a sample; overrides leave windows alone
		assign req.wr    = advance && (item_s1.mode == MODE_SAMPLE)
			&& (PRESENT_W'(c) < present_sat);
		assign req.speed = spd[c];

		mssd_chan #(
			.WINDOW (WINDOW)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req),
			.sum_upd (sums[c])
		);
	end

	// absent channels still take part through their held sums
	mssd_judge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_judge (
		.sums      (sums),
		.threshold (thr_q),
		.best      (best),
		.at_rest   (at_rest)
	);

	assign new_flag = (item_s1.mode == MODE_OVERRIDE) ? item_s1.external_static : at_rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (speed.ready) begin
			valid_s1 <= speed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (speed.ready && speed.valid) begin
			item_s1 <= speed.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flag_q <= new_flag;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (status.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// load the result register; the maximum drops to zero for an override request
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.static_now      <= new_flag;
			res_q.previous_static <= flag_q;
			res_q.max_window_sum  <= (item_s1.mode == MODE_OVERRIDE) ? '0 : best;
		end
	end

endmodule

FILE: rtl/mssd_check.sv
module mssd_check (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   speed_valid,
	input logic                   speed_ready,
	input logic                   status_valid,
	input logic                   status_ready,
	input mssd_pkg::status_item_t status_data
);
	import mssd_pkg::*;

	logic last_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flag_q <= 1'b0;
		end else if (status_valid && status_ready) begin
			last_flag_q <= status_data.static_now;
		end
	end

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid)
		else $error("result dropped while stalled");

	a_status_stable: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> $stable(status_data))
		else $error("result changed while stalled");

	a_prev_chain: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status_data.previous_static == last_flag_q)
		else $error("previous flag does not match last delivered flag");

	a_rise_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid) |-> $past(speed_valid && speed_ready, 2))
		else $error("result appeared without an accepted request");

endmodule

bind multichannel_standstill_detector_unit mssd_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.speed_valid  (speed.valid),
	.speed_ready  (speed.ready),
	.status_valid (status.valid),
	.status_ready (status.ready),
	.status_data  (status.data)
);

FILE: test/tb_multichannel_standstill_detector_unit.sv
module tb_multichannel_standstill_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mssd_pkg::*;

	localparam int   NCH           = NUM_CHANNELS_DEF;
	localparam int   WIN           = WINDOW_DEF;
	// a full window of the most negative speed sums to exactly this
	localparam sum_t THRESHOLD_MAX = 21'd1638400;

	// speed content of the random phases
	typedef enum int {PROFILE_QUIET, PROFILE_FULL, PROFILE_PEAK} speed_profile_t;

	// Standstill predictor: keeps its own windows, running sums and flags, works out
	// the status for every accepted request and matches the returned status in order.
	class standstill_scoreboard_t;
		speed_t       history[NCH][WIN];
		int           fill[NCH];
		int           run_sum[NCH];
		int           slot[NCH];
		bit           flag;
		bit           prev_flag;
		int           threshold;
		status_item_t awaited[$];
		int           failures;

		function int magnitude(speed_t s);
			return (s < 0) ? -int'(s) : int'(s);
		endfunction

		function speed_t lane(speed_item_t it, int c);
			case (c)
				0:       return it.speed_ch0;
				1:       return it.speed_ch1;
				2:       return it.speed_ch2;
				default: return it.speed_ch3;
			endcase
		endfunction

		function void set_threshold(sum_t value);
			threshold = value;
		endfunction

		function void note_request(speed_item_t it);
			status_item_t want;
			int           lanes;
			int           best;
			bit           next_flag;
			speed_t       s;
			best = 0;
			if (it.mode == MODE_OVERRIDE) begin
				next_flag = it.external_static;
			end else begin
				lanes = (it.channels_present > NCH) ? NCH : it.channels_present;
				for (int c = 0; c < lanes; c++) begin
					s = lane(it, c);
					// full window: the oldest sample leaves the sum before it is overwritten
					if (fill[c] >= WIN)
						run_sum[c] -= magnitude(history[c][slot[c]]);
					else
						fill[c]++;
					history[c][slot[c]] = s;
					run_sum[c] += magnitude(s);
					slot[c] = (slot[c] + 1 >= WIN) ? 0 : slot[c] + 1;
				end
				// absent channels still take part in the maximum
				for (int c = 0; c < NCH; c++)
					if (run_sum[c] > best)
						best = run_sum[c];
				next_flag = (best <= threshold);
			end
			prev_flag = flag;
			flag = next_flag;
			want.static_now = flag;
			want.previous_static = prev_flag;
			want.max_window_sum = sum_t'(best);
			awaited = {awaited, want};
		endfunction

		function void check_result(status_item_t got);
			status_item_t want;
			if (awaited.size() == 0) begin
				failures++;
				$display("%0t: status with no request awaiting it: static %0d prev %0d sum %0d",
					$time, got.static_now, got.previous_static, got.max_window_sum);
				return;
			end
			want = awaited.pop_front();
			if (got.static_now !== want.static_now) begin
				failures++;
				$display("%0t: static_now expected %0d actual %0d",
					$time, want.static_now, got.static_now);
			end
			if (got.previous_static !== want.previous_static) begin
				failures++;
				$display("%0t: previous_static expected %0d actual %0d",
					$time, want.previous_static, got.previous_static);
			end
			if (got.max_window_sum !== want.max_window_sum) begin
				failures++;
				$display("%0t: max_window_sum expected %0d actual %0d",
					$time, want.max_window_sum, got.max_window_sum);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;  // while set, neither side idles

	mssd_speed_if  speed_bus ();
	mssd_status_if status_bus ();
	mssd_cfg_if    cfg_bus ();

	standstill_scoreboard_t sb = new;

	multichannel_standstill_detector_unit #(
		.NUM_CHANNELS (NCH),
		.WINDOW       (WIN)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.speed  (speed_bus),
		.status (status_bus),
		.cfg    (cfg_bus)
	);

	always #6 clk = ~clk;

	// Result side: stall about a fifth of the time, never during a steady stretch.
	always @(negedge clk) begin
		status_bus.ready <= steady || ($urandom_range(99) >= 20);
	end

	// Sample each returned status at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && status_bus.valid && status_bus.ready)
			sb.check_result(status_bus.data);
	end

	// Build one request from given field values.
	function automatic speed_item_t compose(logic mode, int present, int s0, int s1, int s2,
		int s3, bit ext);
		speed_item_t it;
		it.mode             = mode;
		it.channels_present = present[PRESENT_W-1:0];
		it.speed_ch0        = speed_t'(s0);
		it.speed_ch1        = speed_t'(s1);
		it.speed_ch2        = speed_t'(s2);
		it.speed_ch3        = speed_t'(s3);
		it.external_static  = ext;
		return it;
	endfunction

	// Random request: mostly samples over all four channels, with overrides and odd
	// channel counts mixed in as noise. The speeds follow the phase profile.
	function automatic speed_item_t random_request(speed_profile_t profile);
		int s[4];
		int present;
		for (int c = 0; c < 4; c++) begin
			case (profile)
				PROFILE_QUIET: s[c] = int'($urandom_range(80)) - 40;
				PROFILE_PEAK:  s[c] = -32768;
				default:       s[c] = int'($urandom_range(65535)) - 32768;
			endcase
		end
		if (profile == PROFILE_PEAK)
			present = $urandom_range(4, 7);
		else
			present = ($urandom_range(9) < 6) ? 4 : $urandom_range(7);
		return compose(($urandom_range(99) < 8) ? MODE_OVERRIDE : MODE_SAMPLE, present,
			s[0], s[1], s[2], s[3], 1'($urandom_range(1)));
	endfunction

	// Drop the request valid and scramble the payload it no longer guards.
	task automatic hold_speed();
		speed_bus.valid <= 1'b0;
		speed_bus.data  <= compose(1'($urandom_range(1)), $urandom_range(7),
			$urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
	endtask

	// Offer one request from a falling edge, note it once accepted, and return on the
	// next falling edge with valid still high so back-to-back requests need no gap.
	task automatic send(speed_item_t it);
		while (!steady && $urandom_range(99) < 20) begin
			hold_speed();
			@(negedge clk);
		end
		speed_bus.valid <= 1'b1;
		speed_bus.data  <= it;
		do @(posedge clk); while (!speed_bus.ready);
		sb.note_request(it);
		@(negedge clk);
	endtask

	// Write the threshold once the pipeline has drained; called on a falling edge.
	task automatic write_threshold(sum_t value);
		hold_speed();
		while (sb.pending() != 0)
			@(negedge clk);
		// let the two-stage pipeline settle fully before touching the register
		repeat (4) @(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_threshold(value);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// One random phase: set the threshold, then stream requests of one profile,
	// holding both sides busy for the first calm requests.
	task automatic run_phase(sum_t value, speed_profile_t profile, int count, int calm);
		write_threshold(value);
		for (int i = 0; i < count; i++) begin
			steady = (i < calm);
			send(random_request(profile));
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		steady           = 1'b0;
		speed_bus.valid  = 1'b0;
		speed_bus.data   = '0;
		status_bus.ready = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.data     = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset threshold of zero.
		// nothing written yet: every sum is zero, so this reads as standing still
		send(compose(MODE_SAMPLE, 0, 0, 0, 0, 0, 0));
		// overrides ignore speeds and channel count and report a zero sum
		send(compose(MODE_OVERRIDE, 7, -32768, 32767, -1, 0, 0));
		send(compose(MODE_OVERRIDE, 0, 0, 0, 0, 0, 1));
		send(compose(MODE_SAMPLE, 1, -32768, 32767, 32767, 32767, 1));
		send(compose(MODE_SAMPLE, 2, 32767, -1, -32768, -32768, 0));
		send(compose(MODE_SAMPLE, 3, 0, 1, -32768, 32767, 1));
		send(compose(MODE_SAMPLE, 4, 32767, 32767, 32767, 32767, 0));
		// too many channels saturate to four
		send(compose(MODE_SAMPLE, 5, -32768, -32768, -32768, -32768, 0));
		send(compose(MODE_SAMPLE, 7, -1, -1, -1, -1, 1));
		send(compose(MODE_SAMPLE, 6, 0, 0, 0, 0, 0));
		// no channel present: absent channels keep their sums for the maximum
		send(compose(MODE_SAMPLE, 0, 32767, 32767, 32767, 32767, 1));
		send(compose(MODE_OVERRIDE, 4, 0, 0, 0, 0, 0));
		send(compose(MODE_OVERRIDE, 4, 0, 0, 0, 0, 1));

		write_threshold(THRESHOLD_MAX);
		send(compose(MODE_SAMPLE, 4, -32768, -32768, -32768, -32768, 0));
		send(compose(MODE_OVERRIDE, 0, 0, 0, 0, 0, 0));
		send(compose(MODE_SAMPLE, 0, 0, 0, 0, 0, 0));
		write_threshold(sum_t'(1));
		send(compose(MODE_SAMPLE, 1, 1, 0, 0, 0, 0));
		send(compose(MODE_SAMPLE, 4, 0, 0, 0, 0, 0));

		// Random part: thresholds at both extremes, near the quiet sums and anywhere.
		run_phase(THRESHOLD_MAX, PROFILE_FULL, 100, 0);
		// fill every window with the most negative speed: sum lands on the maximum
		run_phase(THRESHOLD_MAX, PROFILE_PEAK, 60, 60);
		run_phase(sum_t'(THRESHOLD_MAX - 1), PROFILE_PEAK, 20, 0);
		run_phase(sum_t'($urandom_range(900, 1200)), PROFILE_QUIET, 150, 100);
		run_phase('0, PROFILE_QUIET, 60, 0);
		run_phase(sum_t'($urandom_range(THRESHOLD_MAX)), PROFILE_FULL, 100, 0);
		run_phase(sum_t'($urandom_range(950, 1150)), PROFILE_QUIET, 200, 0);

		// Drain: wait for every status, then keep watching for anything stray.
		hold_speed();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mssd_pkg.sv
rtl/mssd_if.sv
rtl/mssd_chan.sv
rtl/mssd_judge.sv
rtl/multichannel_standstill_detector_unit.sv
rtl/mssd_check.sv
test/tb_multichannel_standstill_detector_unit.sv
